@@ hdl/wbit_pkg.sv @@
// ============================================================================
// Work/break interval timer package
// Shared types and constants for the phase timer and its channels.
// ============================================================================
package wbit_pkg;

    // Item kinds on the input channel.
    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_CONFIRM = 3'd1,
        KIND_BACK    = 3'd2,
        KIND_UP      = 3'd3,
        KIND_DOWN    = 3'd4
    } kind_t;

    // Timer phases.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WORK  = 2'd1,
        PH_SHORT = 2'd2,
        PH_LONG  = 2'd3
    } phase_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WORK_MS     = 2'd0;
    localparam logic [1:0] CFG_SHORT_MS    = 2'd1;
    localparam logic [1:0] CFG_LONG_MS     = 2'd2;
    localparam logic [1:0] CFG_CYCLES_LONG = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Reset values of the configuration registers.
    localparam logic [31:0] WORK_MS_RESET   = 32'd1500000;
    localparam logic [31:0] SHORT_MS_RESET  = 32'd300000;
    localparam logic [31:0] LONG_MS_RESET   = 32'd900000;
    localparam logic [3:0]  CYCLES_RESET    = 4'd4;

    localparam logic [31:0] MINUTE_MS       = 32'd60000;
    localparam logic [31:0] TIME_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] UP_LIMIT        = TIME_MAX - MINUTE_MS;
    localparam logic [15:0] DONE_MAX        = 16'hFFFF;

    // Configuration register file.
    typedef struct packed {
        logic [31:0] work_ms;
        logic [31:0] short_break_ms;
        logic [31:0] long_break_ms;
        logic [3:0]  cycles_per_long_break;
    } cfg_t;

    // Timer state carried from item to item.
    typedef struct packed {
        phase_t      phase;
        logic        paused;
        logic [31:0] remaining;
        logic [3:0]  cycles;
        logic [15:0] completed;
    } timer_state_t;

    // Per-item event flags.
    typedef struct packed {
        logic expired;
        logic exit_req;
    } step_flags_t;

endpackage

@@ hdl/wbit_in_if.sv @@
// ============================================================================
// Timer input channel
// Carries one tick or button word with a valid/ready handshake.
// ============================================================================
interface wbit_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] elapsed_ms;

    modport source (output valid, output kind, output elapsed_ms, input ready);
    modport sink   (input valid, input kind, input elapsed_ms, output ready);
endinterface

@@ hdl/wbit_out_if.sv @@
// ============================================================================
// Timer result channel
// Carries one status word per input word with a valid/ready handshake.
// ============================================================================
interface wbit_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  phase;
    logic        is_paused;
    logic [31:0] time_left_ms;
    logic [3:0]  cycle_position;
    logic [15:0] work_done_count;
    logic        phase_expired;
    logic        exit_request;

    modport source (output valid, output phase, output is_paused, output time_left_ms,
                    output cycle_position, output work_done_count,
                    output phase_expired, output exit_request, input ready);
    modport sink   (input valid, input phase, input is_paused, input time_left_ms,
                    input cycle_position, input work_done_count,
                    input phase_expired, input exit_request, output ready);
endinterface

@@ hdl/wbit_step.sv @@
// ============================================================================
// Timer step logic
// Computes the next timer state and event flags for one input word.
// ============================================================================
module wbit_step
    import wbit_pkg::*;
(
    input  timer_state_t cur,
    input  cfg_t         cfg,
    input  logic [2:0]   kind,
    input  logic [15:0]  elapsed_ms,
    output timer_state_t nxt,
    output step_flags_t  flags
);

    logic [31:0] elapsed_ext;
    logic [31:0] tick_left;
    logic [4:0]  cycles_inc;
    logic        go_long;

    // Saturating countdown for a running tick.
    assign elapsed_ext = {16'd0, elapsed_ms};
    assign tick_left   = (elapsed_ext >= cur.remaining) ? 32'd0
                                                        : cur.remaining - elapsed_ext;

    // Cycle position after a finished work phase.
    assign cycles_inc = {1'b0, cur.cycles} + 5'd1;
    assign go_long    = (cycles_inc >= {1'b0, cfg.cycles_per_long_break});

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        case (kind)
            KIND_TICK:
            begin
                if (!cur.paused && cur.phase != PH_IDLE)
                begin
                    nxt.remaining = tick_left;
                    if (tick_left == 32'd0)
                    begin
                        flags.expired = 1'b1;
                        nxt.paused    = 1'b0;
                        if (cur.phase == PH_WORK)
                        begin
                            if (cur.completed != DONE_MAX)
                            begin
                                nxt.completed = cur.completed + 16'd1;
                            end
                            if (go_long)
                            begin
                                nxt.cycles    = 4'd0;
                                nxt.phase     = PH_LONG;
                                nxt.remaining = cfg.long_break_ms;
                            end
                            else
                            begin
                                nxt.cycles    = cycles_inc[3:0];
                                nxt.phase     = PH_SHORT;
                                nxt.remaining = cfg.short_break_ms;
                            end
                        end
                        else
                        begin
                            nxt.phase     = PH_WORK;
                            nxt.remaining = cfg.work_ms;
                        end
                    end
                end
            end
            KIND_CONFIRM:
            begin
                if (cur.phase == PH_IDLE)
                begin
                    nxt.phase     = PH_WORK;
                    nxt.paused    = 1'b0;
                    nxt.remaining = cfg.work_ms;
                end
                else
                begin
                    nxt.paused = !cur.paused;
                end
            end
            KIND_BACK:
            begin
                if (cur.phase == PH_IDLE)
                begin
                    flags.exit_req = 1'b1;
                end
                else
                begin
                    nxt.phase     = PH_IDLE;
                    nxt.paused    = 1'b0;
                    nxt.remaining = cfg.work_ms;
                end
            end
            KIND_UP:
            begin
                nxt.remaining = (cur.remaining > UP_LIMIT) ? TIME_MAX
                                                           : cur.remaining + MINUTE_MS;
            end
            KIND_DOWN:
            begin
                nxt.remaining = (cur.remaining > MINUTE_MS) ? cur.remaining - MINUTE_MS
                                                            : 32'd0;
            end
            default:
            begin
                // Unused kinds leave the state alone.
                nxt = cur;
            end
        endcase
    end

endmodule

@@ hdl/work_break_interval_timer.sv @@
// ============================================================================
// Work/break interval timer
// Counts down work, short break and long break phases from tick and button
// words and reports the timer status after every word.
// ============================================================================
//
//  Channel   Dir   Handshake        Payload
//  in_ch     in    valid/ready      kind, elapsed_ms
//  out_ch    out   valid/ready      phase, is_paused, time_left_ms,
//                                   cycle_position, work_done_count,
//                                   phase_expired, exit_request
//  cfg       in    cfg_we           cfg_index, cfg_data
//
//  One word is accepted per cycle while the result channel does not stall;
//  each word passes the input register, then the result register.
//  The combinational state update between those registers sets that rate.
//  Reset loads the configuration defaults and the idle timer state.
//  While a result waits, one more word is still taken into the input register.
//
module work_break_interval_timer
    import wbit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    wbit_in_if.sink                in_ch,
    wbit_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg_reg;
    timer_state_t state_reg;
    timer_state_t state_next;
    step_flags_t  flags_next;

    logic        in_valid_reg;
    logic [2:0]  in_kind_reg;
    logic [15:0] in_elapsed_reg;

    logic        out_valid_reg;
    logic [1:0]  out_phase_reg;
    logic        out_paused_reg;
    logic [31:0] out_time_reg;
    logic [3:0]  out_cycles_reg;
    logic [15:0] out_done_reg;
    logic        out_expired_reg;
    logic        out_exit_reg;

    logic in_accept;
    logic step_go;

    // Handshake control.
    assign step_go     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step_go;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.work_ms               <= WORK_MS_RESET;
            cfg_reg.short_break_ms        <= SHORT_MS_RESET;
            cfg_reg.long_break_ms         <= LONG_MS_RESET;
            cfg_reg.cycles_per_long_break <= CYCLES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WORK_MS:     cfg_reg.work_ms        <= cfg_data;
                CFG_SHORT_MS:    cfg_reg.short_break_ms <= cfg_data;
                CFG_LONG_MS:     cfg_reg.long_break_ms  <= cfg_data;
                CFG_CYCLES_LONG: cfg_reg.cycles_per_long_break <= cfg_data[3:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg    <= in_ch.kind;
            in_elapsed_reg <= in_ch.elapsed_ms;
        end
    end

    // Next-state logic for the registered word.
    wbit_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .kind       (in_kind_reg),
        .elapsed_ms (in_elapsed_reg),
        .nxt        (state_next),
        .flags      (flags_next)
    );

    // Timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.paused    <= 1'b0;
            state_reg.remaining <= WORK_MS_RESET;
            state_reg.cycles    <= 4'd0;
            state_reg.completed <= 16'd0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            out_phase_reg   <= state_next.phase;
            out_paused_reg  <= state_next.paused;
            out_time_reg    <= state_next.remaining;
            out_cycles_reg  <= state_next.cycles;
            out_done_reg    <= state_next.completed;
            out_expired_reg <= flags_next.expired;
            out_exit_reg    <= flags_next.exit_req;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.phase           = out_phase_reg;
    assign out_ch.is_paused       = out_paused_reg;
    assign out_ch.time_left_ms    = out_time_reg;
    assign out_ch.cycle_position  = out_cycles_reg;
    assign out_ch.work_done_count = out_done_reg;
    assign out_ch.phase_expired   = out_expired_reg;
    assign out_ch.exit_request    = out_exit_reg;

    // A paused timer is never idle.
    a_pause_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.paused |-> (state_reg.phase != PH_IDLE))
        else $error("paused while idle");

    // An exit request only comes with an idle result.
    a_exit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_exit_reg) |-> (out_phase_reg == PH_IDLE && !out_expired_reg))
        else $error("exit request outside idle");

    // A phase change by expiry always starts the new phase running.
    a_expire_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_expired_reg) |-> (!out_paused_reg && out_phase_reg != PH_IDLE))
        else $error("expired into paused or idle phase");

    // The completed count never goes down.
    a_done_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> (state_reg.completed >= $past(state_reg.completed)))
        else $error("completed count decreased");

    // State only moves when a word advances.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_go |=> $stable(state_reg))
        else $error("state changed without a word");

endmodule

@@ tb/sv/timer_check_pkg.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Interval timer status tracker
// Keeps its own copy of the timer state and registers, works out the status
// word due for every accepted input word, and checks the words the timer
// returns in order.
// ============================================================================
package timer_check_pkg;

    import wbit_pkg::*;

    // Input kinds that the timer has no use for.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    // Status reported by the timer after one word.
    typedef struct packed {
        logic [1:0]  phase;
        logic        is_paused;
        logic [31:0] time_left;
        logic [3:0]  cycle_pos;
        logic [15:0] done;
        logic        expired;
        logic        exit_req;
    } timer_status_t;

    class timer_status_tracker;
        // Register copies.
        logic [31:0] work_len;
        logic [31:0] short_len;
        logic [31:0] long_len;
        logic [3:0]  long_every;

        // Timer state copies.
        phase_t      phase;
        logic        paused;
        logic [31:0] left;
        logic [4:0]  cycle_pos;
        logic [15:0] done;

        timer_status_t pending_status[$];
        int unsigned   mismatches;

        // Return to the state right after reset.
        function void clear();
            work_len        = WORK_MS_RESET;
            short_len       = SHORT_MS_RESET;
            long_len        = LONG_MS_RESET;
            long_every      = CYCLES_RESET;
            phase           = PH_IDLE;
            paused          = 1'b0;
            left            = WORK_MS_RESET;
            cycle_pos       = '0;
            done            = '0;
            mismatches      = 0;
            pending_status.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_WORK_MS:     work_len   = value;
                CFG_SHORT_MS:    short_len  = value;
                CFG_LONG_MS:     long_len   = value;
                CFG_CYCLES_LONG: long_every = value[3:0];
                default: ;
            endcase
        endfunction

        function void start_phase(phase_t next, logic [31:0] len);
            phase  = next;
            paused = 1'b0;
            left   = len;
        endfunction

        // Advance the state by one accepted word and queue the status it yields.
        function void note_word(logic [2:0] kind, logic [15:0] elapsed);
            timer_status_t want;
            logic          expired;
            logic          exit_req;
            expired  = 1'b0;
            exit_req = 1'b0;
            case (kind)
                KIND_TICK:
                begin
                    if (!paused && phase != PH_IDLE)
                    begin
                        if ({16'd0, elapsed} >= left)
                            left = '0;
                        else
                            left = left - {16'd0, elapsed};
                        // A phase that runs out hands over to the next one.
                        if (left == '0)
                        begin
                            expired = 1'b1;
                            if (phase == PH_WORK)
                            begin
                                if (done != DONE_MAX)
                                    done = done + 16'd1;
                                cycle_pos = cycle_pos + 5'd1;
                                if (cycle_pos >= {1'b0, long_every})
                                begin
                                    cycle_pos = '0;
                                    start_phase(PH_LONG, long_len);
                                end
                                else
                                begin
                                    start_phase(PH_SHORT, short_len);
                                end
                            end
                            else
                            begin
                                start_phase(PH_WORK, work_len);
                            end
                        end
                    end
                end
                KIND_CONFIRM:
                begin
                    if (phase == PH_IDLE)
                        start_phase(PH_WORK, work_len);
                    else
                        paused = !paused;
                end
                KIND_BACK:
                begin
                    if (phase == PH_IDLE)
                        exit_req = 1'b1;
                    else
                        start_phase(PH_IDLE, work_len);
                end
                KIND_UP:
                begin
                    if (left > UP_LIMIT)
                        left = TIME_MAX;
                    else
                        left = left + MINUTE_MS;
                end
                KIND_DOWN:
                begin
                    if (left > MINUTE_MS)
                        left = left - MINUTE_MS;
                    else
                        left = '0;
                end
                default: ;
            endcase
            want.phase     = phase;
            want.is_paused = paused;
            want.time_left = left;
            want.cycle_pos = cycle_pos[3:0];
            want.done      = done;
            want.expired   = expired;
            want.exit_req  = exit_req;
            pending_status.push_back(want);
        endfunction

        // Compare one returned status word with the oldest one due.
        function void check_status(timer_status_t got);
            timer_status_t want;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status word: phase %0d left %0d", got.phase,
                             got.time_left);
                return;
            end
            want = pending_status.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("status mismatch at %0t", $realtime);
                    $display("  expected phase %0d paused %0b left %0d pos %0d",
                             want.phase, want.is_paused, want.time_left, want.cycle_pos);
                    $display("           done %0d exp %0b exit %0b",
                             want.done, want.expired, want.exit_req);
                    $display("  actual   phase %0d paused %0b left %0d pos %0d",
                             got.phase, got.is_paused, got.time_left, got.cycle_pos);
                    $display("           done %0d exp %0b exit %0b",
                             got.done, got.expired, got.exit_req);
                end
            end
        endfunction
    endclass

endpackage

@@ tb/sv/work_break_interval_timer_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Interval timer testbench
// Drives tick and button words through the timer under several register
// settings, with random input gaps and output stalls, and checks every
// status word against a tracked copy of the timer state.
// ============================================================================
module work_break_interval_timer_test;

    import wbit_pkg::*;
    import timer_check_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_WORDS = 130;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wbit_in_if  in_ch ();
    wbit_out_if out_ch ();

    timer_status_tracker tracker;

    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    work_break_interval_timer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Offer one word and hold it until the timer takes it.
    task automatic send_word(logic [2:0] kind, logic [15:0] elapsed);
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.elapsed_ms <= elapsed;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic idle_input(int unsigned cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every status word has come back and the pipeline is empty.
    task automatic settle();
        idle_input(1);
        while (tracker.pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles.
    task automatic load_config(logic [31:0] work_len, logic [31:0] short_len,
                               logic [31:0] long_len, logic [3:0] long_every);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WORK_MS;
        cfg_data  <= work_len;
        @(posedge clk);
        cfg_index <= CFG_SHORT_MS;
        cfg_data  <= short_len;
        @(posedge clk);
        cfg_index <= CFG_LONG_MS;
        cfg_data  <= long_len;
        @(posedge clk);
        cfg_index <= CFG_CYCLES_LONG;
        cfg_data  <= {28'd0, long_every};
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(CFG_WORK_MS, work_len);
        tracker.set_reg(CFG_SHORT_MS, short_len);
        tracker.set_reg(CFG_LONG_MS, long_len);
        tracker.set_reg(CFG_CYCLES_LONG, {28'd0, long_every});
    endtask

    // Random words in bursts, mostly ticks, until the given number was sent.
    task automatic send_random_words(int unsigned target);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        int unsigned spread;
        logic [2:0]  kind;
        logic [15:0] elapsed;
        sent  = 0;
        burst = 0;
        while (sent < target)
        begin
            if (burst == 0)
            begin
                if (tx_gaps_on)
                    idle_input($urandom_range(1, 12));
                burst = $urandom_range(1, 24);
            end
            pick = $urandom_range(0, 99);
            if (pick < 58)
                kind = KIND_TICK;
            else if (pick < 70)
                kind = KIND_CONFIRM;
            else if (pick < 75)
                kind = KIND_BACK;
            else if (pick < 85)
                kind = KIND_UP;
            else if (pick < 95)
                kind = KIND_DOWN;
            else
                kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            spread = $urandom_range(0, 9);
            if (spread == 0)
                elapsed = '0;
            else if (spread == 1)
                elapsed = 16'hFFFF;
            else if (spread == 2)
                elapsed = 16'($urandom_range(0, 255));
            else
                elapsed = 16'($urandom_range(0, 65535));
            send_word(kind, elapsed);
            sent++;
            burst--;
        end
    endtask

    // Output side: stall patterns that change per window, plus one long hold.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned window;
        int unsigned mode;
        int unsigned rx_count;
        hold_left = 0;
        window    = 0;
        mode      = 0;
        rx_count  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_count++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!rx_stalls_on)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                if (window == 0)
                begin
                    mode   = $urandom_range(0, 3);
                    window = $urandom_range(8, 64);
                end
                window--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (rx_count % 4) != 0;
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Record accepted input words and check accepted status words.
    always @(posedge clk)
    begin : observe
        timer_status_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_word(in_ch.kind, in_ch.elapsed_ms);
            if (out_ch.valid && out_ch.ready)
            begin
                got.phase     = out_ch.phase;
                got.is_paused = out_ch.is_paused;
                got.time_left = out_ch.time_left_ms;
                got.cycle_pos = out_ch.cycle_position;
                got.done      = out_ch.work_done_count;
                got.expired   = out_ch.phase_expired;
                got.exit_req  = out_ch.exit_request;
                tracker.check_status(got);
            end
        end
    end

    // End the run if neither side moves a word for too long.
    always @(posedge clk)
    begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("work_break_interval_timer test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        tracker = new;
        tracker.clear();
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_TICK;
        in_ch.elapsed_ms <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_WORK_MS;
        cfg_data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset register values.
        tx_gaps_on = 1'b0;
        send_word(KIND_BACK, 16'd0);          // exit request while idle
        send_word(KIND_TICK, 16'hFFFF);       // ignored while idle
        send_word(KIND_SPARE_FIRST, 16'hFFFF);
        send_word(KIND_SPARE_LAST, 16'd0);
        send_word(KIND_UP, 16'd0);
        send_word(KIND_DOWN, 16'hFFFF);
        send_word(KIND_CONFIRM, 16'd0);       // start work
        send_word(KIND_CONFIRM, 16'd0);       // pause
        send_word(KIND_TICK, 16'hFFFF);       // ignored while paused
        send_word(KIND_CONFIRM, 16'd0);       // resume
        send_word(KIND_TICK, 16'd0);
        send_word(KIND_TICK, 16'hFFFF);
        send_word(KIND_BACK, 16'd0);          // back to idle
        settle();

        // Directed words around zero time, saturation and a zero cycle count.
        load_config(32'd30000, 32'd0, TIME_MAX, 4'd0);
        send_word(KIND_CONFIRM, 16'd0);
        send_word(KIND_DOWN, 16'd0);          // floors at zero
        send_word(KIND_TICK, 16'd0);          // zero time ends the work phase
        send_word(KIND_UP, 16'd0);            // saturates
        send_word(KIND_DOWN, 16'd0);
        send_word(KIND_TICK, 16'hFFFF);
        send_word(KIND_CONFIRM, 16'd0);
        send_word(KIND_UP, 16'd0);            // adjusts even while paused
        send_word(KIND_CONFIRM, 16'd0);
        send_word(KIND_BACK, 16'd0);
        send_word(KIND_CONFIRM, 16'd0);
        send_word(KIND_TICK, 16'hFFFF);       // every work phase ends in a long break
        settle();

        // Random words over a series of register settings.
        tx_gaps_on = 1'b1;
        load_config(32'd200000, 32'd70000, 32'd130000, 4'd4);
        hold_request = 1'b1;
        send_random_words(PHASE_WORDS);
        settle();

        load_config(32'd0, 32'd0, 32'd0, 4'd1);
        send_random_words(PHASE_WORDS);
        settle();

        // A high count lets the position climb before the count is lowered.
        load_config(32'd30000, 32'd20000, 32'd50000, 4'd15);
        send_random_words(PHASE_WORDS);
        settle();

        load_config(32'd90000, 32'd40000, 32'd60000, 4'd2);
        send_random_words(PHASE_WORDS);
        settle();

        load_config(TIME_MAX, TIME_MAX, TIME_MAX, 4'd15);
        send_random_words(PHASE_WORDS);
        settle();

        // A stretch with no idling on either side.
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        load_config($urandom_range(0, 300000), $urandom_range(0, 300000),
                    $urandom_range(0, 300000), 4'($urandom_range(1, 15)));
        send_random_words(PHASE_WORDS);
        settle();

        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        load_config($urandom_range(0, 150000), $urandom_range(0, 150000),
                    $urandom_range(0, 150000), 4'($urandom_range(0, 15)));
        send_random_words(PHASE_WORDS);
        settle();

        send_random_words(20);
        settle();

        if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
            $display("work_break_interval_timer test passed");
        else
            $display("work_break_interval_timer test failed");
        $finish;
    end

endmodule
